[rtl/core/bbss_pkg.sv]
// Shared types and constants for the bump, back-up and spin sequencer.
// Holds the event codes, the one-hot mode type, register indexes and reset values.
// No dependencies.
`timescale 1ns / 1ps

package bbss_pkg;

    // Event kinds carried in op
    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_BUMP = 2'd1;
    localparam logic [1:0] OP_YAW  = 2'd2;

    // Mode codes as shown on mode_now
    localparam logic [2:0] CODE_FORWARD = 3'd0;
    localparam logic [2:0] CODE_BACKUP  = 3'd1;
    localparam logic [2:0] CODE_PAUSE1  = 3'd2;
    localparam logic [2:0] CODE_SPIN    = 3'd3;
    localparam logic [2:0] CODE_PAUSE2  = 3'd4;

    // Configuration register indexes
    localparam logic [2:0] REG_FORWARD_SPEED  = 3'd0;
    localparam logic [2:0] REG_BACKUP_SPEED   = 3'd1;
    localparam logic [2:0] REG_SPIN_SPEED     = 3'd2;
    localparam logic [2:0] REG_BACKUP_TICKS   = 3'd3;
    localparam logic [2:0] REG_PAUSE_TICKS    = 3'd4;
    localparam logic [2:0] REG_TIMEOUT_TICKS  = 3'd5;
    localparam logic [2:0] REG_TURN_THRESHOLD = 3'd6;

    // Register reset values
    localparam logic [15:0] RST_FORWARD_SPEED  = 16'd300;
    localparam logic [15:0] RST_BACKUP_SPEED   = 16'hFF38;
    localparam logic [15:0] RST_SPIN_SPEED     = 16'd500;
    localparam logic [15:0] RST_BACKUP_TICKS   = 16'd40;
    localparam logic [15:0] RST_PAUSE_TICKS    = 16'd10;
    localparam logic [15:0] RST_TIMEOUT_TICKS  = 16'd600;
    localparam logic [15:0] RST_TURN_THRESHOLD = 16'd32246;

    // Turned-angle accumulator limits (signed 24 bit)
    localparam int TURN_BITS = 24;
    localparam logic [TURN_BITS-1:0] TURN_MAX = 24'h7FFFFF;
    localparam logic [TURN_BITS-1:0] TURN_MIN = 24'h800000;

    localparam logic [15:0] TICKS_MAX = 16'hFFFF;

    // Sequencer mode, one-hot
    typedef enum logic [4:0] {
        MODE_FORWARD = 5'b00001,
        MODE_BACKUP  = 5'b00010,
        MODE_PAUSE1  = 5'b00100,
        MODE_SPIN    = 5'b01000,
        MODE_PAUSE2  = 5'b10000
    } t_mode;

    // Register file contents handed to the step logic
    typedef struct packed {
        logic signed [15:0] fwd_mmps;
        logic signed [15:0] rev_mmps;
        logic signed [15:0] turn_rate;
        logic [15:0]        backup_ticks;
        logic [15:0]        pause_ticks;
        logic [15:0]        timeout_ticks;
        logic [15:0]        turn_threshold;
    } t_cfg;

    // Result of one step
    typedef struct packed {
        logic               emit;
        logic signed [15:0] linear_speed;
        logic signed [15:0] angular_speed;
        logic [2:0]         mode_now;
    } t_result;

    // Map the one-hot mode to its output code
    function automatic logic [2:0] mode_code(input t_mode m);
        logic [2:0] code;
        unique case (m)
            MODE_FORWARD: code = CODE_FORWARD;
            MODE_BACKUP:  code = CODE_BACKUP;
            MODE_PAUSE1:  code = CODE_PAUSE1;
            MODE_SPIN:    code = CODE_SPIN;
            MODE_PAUSE2:  code = CODE_PAUSE2;
            default:      code = CODE_FORWARD;
        endcase
        return code;
    endfunction

endpackage

[rtl/core/bump_backup_spin_sequencer.sv]
// An accepted item waits in the input register until the output register has room;
// it is then stepped, and its result, if any, is loaded into the output register.
// Throughput: one item per cycle, set by the step over the state registers,
// while the output register is not stalled.
// Reset: synchronous, active low; clears mode, counters, heading anchor and both valids,
// and loads the register defaults. No clearing pass.
`timescale 1ns / 1ps

module bump_backup_spin_sequencer #(
    parameter int BUMP_SENSORS = 8,
    parameter int ANGLE_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // event item channel
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_bump_mask,
    input  logic signed [15:0]   i_yaw_angle,
    // result item channel
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic signed [15:0]   o_linear_speed,
    output logic signed [15:0]   o_angular_speed,
    output logic [2:0]           o_mode_now,
    // configuration writes
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data
);

    bbss_pkg::t_cfg    cfg;
    bbss_pkg::t_result res;

    logic               r_in_valid;
    logic [1:0]         r_in_op;
    logic [7:0]         r_in_mask;
    logic signed [15:0] r_in_yaw;
    logic               r_out_valid;
    logic signed [15:0] r_out_lin, r_out_ang;
    logic [2:0]         r_out_mode;
    logic               advance;

    // Step the held item once the output register has room
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    bbss_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    bbss_step #(
        .BUMP_SENSORS (BUMP_SENSORS),
        .ANGLE_BITS   (ANGLE_BITS)
    ) u_step (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_op        (r_in_op),
        .i_bump_mask (r_in_mask),
        .i_yaw_angle (r_in_yaw),
        .i_cfg       (cfg),
        .o_result    (res)
    );

    // Input register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    // Capture the item payload on acceptance
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_op   <= i_op;
            r_in_mask <= i_bump_mask;
            r_in_yaw  <= i_yaw_angle;
        end
    end

    // Output register valid: load on a result, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res.emit) begin
            r_out_lin  <= res.linear_speed;
            r_out_ang  <= res.angular_speed;
            r_out_mode <= res.mode_now;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_linear_speed  = r_out_lin;
    assign o_angular_speed = r_out_ang;
    assign o_mode_now      = r_out_mode;

endmodule

[rtl/core/bbss_cfg.sv]
// Configuration register file for the sequencer.
// Uses bbss_pkg for register indexes, reset values and the t_cfg struct.
`timescale 1ns / 1ps

module bbss_cfg (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [15:0]          i_cfg_data,
    output bbss_pkg::t_cfg       o_cfg
);

    bbss_pkg::t_cfg r_cfg;

    // Write one register per enabled cycle; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fwd_mmps       <= bbss_pkg::RST_FORWARD_SPEED;
            r_cfg.rev_mmps       <= bbss_pkg::RST_BACKUP_SPEED;
            r_cfg.turn_rate      <= bbss_pkg::RST_SPIN_SPEED;
            r_cfg.backup_ticks   <= bbss_pkg::RST_BACKUP_TICKS;
            r_cfg.pause_ticks    <= bbss_pkg::RST_PAUSE_TICKS;
            r_cfg.timeout_ticks  <= bbss_pkg::RST_TIMEOUT_TICKS;
            r_cfg.turn_threshold <= bbss_pkg::RST_TURN_THRESHOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                bbss_pkg::REG_FORWARD_SPEED:  r_cfg.fwd_mmps       <= i_cfg_data;
                bbss_pkg::REG_BACKUP_SPEED:   r_cfg.rev_mmps       <= i_cfg_data;
                bbss_pkg::REG_SPIN_SPEED:     r_cfg.turn_rate      <= i_cfg_data;
                bbss_pkg::REG_BACKUP_TICKS:   r_cfg.backup_ticks   <= i_cfg_data;
                bbss_pkg::REG_PAUSE_TICKS:    r_cfg.pause_ticks    <= i_cfg_data;
                bbss_pkg::REG_TIMEOUT_TICKS:  r_cfg.timeout_ticks  <= i_cfg_data;
                bbss_pkg::REG_TURN_THRESHOLD: r_cfg.turn_threshold <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/core/bbss_step.sv]
// Sequencer state and the single-pass step logic for one event item.
// Uses bbss_pkg for the mode type, event codes, t_cfg and t_result.
`timescale 1ns / 1ps

module bbss_step #(
    parameter int BUMP_SENSORS = 8,
    parameter int ANGLE_BITS   = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_en,
    input  logic [1:0]           i_op,
    input  logic [7:0]           i_bump_mask,
    input  logic signed [15:0]   i_yaw_angle,
    input  bbss_pkg::t_cfg       i_cfg,
    output bbss_pkg::t_result    o_result
);

    localparam int TB = bbss_pkg::TURN_BITS;
    // Only eight sensor bits reach the block
    localparam int SENSE_USED = (BUMP_SENSORS < 8) ? BUMP_SENSORS : 8;
    localparam logic [7:0] SENSE_MASK = 8'((16'd1 << SENSE_USED) - 16'd1);

    bbss_pkg::t_mode         r_mode, n_mode;
    logic [15:0]             r_ticks, n_ticks;
    logic [ANGLE_BITS-1:0]   r_last, n_last;
    logic [TB-1:0]           r_turned, n_turned;
    logic                    r_anchored, n_anchored;

    logic [15:0]             ticks_inc;
    logic signed [31:0]      yaw_ext;
    logic [ANGLE_BITS-1:0]   heading;
    logic signed [ANGLE_BITS-1:0] diff;
    logic signed [TB:0]      sum_wide;
    logic [TB-1:0]           sum_sat;
    logic [TB-1:0]           mag;
    logic                    emit;
    logic signed [15:0]      lin, ang;

    // Saturating tick count and heading arithmetic
    always_comb begin
        ticks_inc = (r_ticks == bbss_pkg::TICKS_MAX) ? r_ticks : r_ticks + 16'd1;
        yaw_ext   = 32'(i_yaw_angle);
        heading   = yaw_ext[ANGLE_BITS-1:0];
        diff      = heading - r_last;
        sum_wide  = (TB+1)'($signed(r_turned)) + (TB+1)'(diff);
        if (sum_wide[TB] != sum_wide[TB-1]) begin
            sum_sat = sum_wide[TB] ? bbss_pkg::TURN_MIN : bbss_pkg::TURN_MAX;
        end else begin
            sum_sat = sum_wide[TB-1:0];
        end
        mag = sum_sat[TB-1] ? (~sum_sat + TB'(1)) : sum_sat;
    end

    // Next state and result for the item in hand
    always_comb begin
        n_mode     = r_mode;
        n_ticks    = r_ticks;
        n_last     = r_last;
        n_turned   = r_turned;
        n_anchored = r_anchored;
        emit       = 1'b0;
        lin        = '0;
        ang        = '0;
        unique case (i_op)
            bbss_pkg::OP_TICK: begin
                n_ticks = ticks_inc;
                unique case (r_mode)
                    bbss_pkg::MODE_FORWARD: begin
                        emit = 1'b1;
                        lin  = i_cfg.fwd_mmps;
                    end
                    bbss_pkg::MODE_BACKUP: begin
                        emit = 1'b1;
                        lin  = i_cfg.rev_mmps;
                        if (ticks_inc >= i_cfg.backup_ticks) begin
                            n_mode  = bbss_pkg::MODE_PAUSE1;
                            n_ticks = '0;
                        end
                    end
                    bbss_pkg::MODE_PAUSE1: begin
                        emit = 1'b1;
                        if (ticks_inc >= i_cfg.pause_ticks) begin
                            n_mode     = bbss_pkg::MODE_SPIN;
                            n_ticks    = '0;
                            n_anchored = 1'b0;
                            n_turned   = '0;
                        end
                    end
                    bbss_pkg::MODE_SPIN: begin
                        if (ticks_inc > i_cfg.timeout_ticks) begin
                            emit    = 1'b1;
                            n_mode  = bbss_pkg::MODE_PAUSE2;
                            n_ticks = '0;
                        end
                    end
                    bbss_pkg::MODE_PAUSE2: begin
                        emit = 1'b1;
                        if (ticks_inc >= i_cfg.pause_ticks) begin
                            n_mode  = bbss_pkg::MODE_FORWARD;
                            n_ticks = '0;
                        end
                    end
                    default: ;
                endcase
            end
            bbss_pkg::OP_BUMP: begin
                if (r_mode == bbss_pkg::MODE_FORWARD && (i_bump_mask & SENSE_MASK) != '0) begin
                    n_mode  = bbss_pkg::MODE_BACKUP;
                    n_ticks = '0;
                end
            end
            bbss_pkg::OP_YAW: begin
                if (r_mode == bbss_pkg::MODE_SPIN) begin
                    n_last = heading;
                    if (!r_anchored) begin
                        n_anchored = 1'b1;
                    end else begin
                        n_turned = sum_sat;
                        emit     = 1'b1;
                        if (mag >= TB'(i_cfg.turn_threshold)) begin
                            n_mode  = bbss_pkg::MODE_PAUSE2;
                            n_ticks = '0;
                        end else begin
                            ang = i_cfg.turn_rate;
                        end
                    end
                end
            end
            default: ;
        endcase
    end

    // Commit the step when the item advances
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= bbss_pkg::MODE_FORWARD;
            r_ticks    <= '0;
            r_last     <= '0;
            r_turned   <= '0;
            r_anchored <= 1'b0;
        end else if (i_en) begin
            r_mode     <= n_mode;
            r_ticks    <= n_ticks;
            r_last     <= n_last;
            r_turned   <= n_turned;
            r_anchored <= n_anchored;
        end
    end

    assign o_result.emit          = emit;
    assign o_result.linear_speed  = lin;
    assign o_result.angular_speed = ang;
    assign o_result.mode_now      = bbss_pkg::mode_code(n_mode);

endmodule

[rtl/core/bbss_checker.sv]
// Port-level checks for the sequencer, bound to the top level.
// Uses bbss_pkg for mode codes; depends on bump_backup_spin_sequencer for the bind.
`timescale 1ns / 1ps

module bbss_checker (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 o_out_valid,
    input  logic                 i_out_ready,
    input  logic signed [15:0]   o_linear_speed,
    input  logic signed [15:0]   o_angular_speed,
    input  logic [2:0]           o_mode_now
);

    // Hold a stalled result item
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result item dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            $stable(o_linear_speed) && $stable(o_angular_speed) && $stable(o_mode_now))
        else $error("stalled result item changed");

    // Turning commands come only from the spin mode
    a_turn_in_spin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_angular_speed != 16'sd0 |->
            o_mode_now == bbss_pkg::CODE_SPIN && o_linear_speed == 16'sd0)
        else $error("angular command outside spin");

    // Driving commands never carry a spin or second-pause mode
    a_drive_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_linear_speed != 16'sd0 |->
            o_mode_now != bbss_pkg::CODE_SPIN && o_mode_now != bbss_pkg::CODE_PAUSE2)
        else $error("linear command in spin or pause");

    // Nothing is offered at the first edge out of reset
    a_reset_idle: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !o_out_valid)
        else $error("result valid right after reset");

endmodule

bind bump_backup_spin_sequencer bbss_checker u_bbss_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_linear_speed  (o_linear_speed),
    .o_angular_speed (o_angular_speed),
    .o_mode_now      (o_mode_now)
);
